/* sv/lpq_pkg.sv */
// shared types, codes and the record ordering for the lexicographic priority queue
`default_nettype none

package lpq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRY_W     = 5;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_TAKE   = 2'd1,
    CMD_PEEK   = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic [3:0]  prio;
    logic [15:0] arrival;
    logic [15:0] service;
    logic [15:0] order;
    logic [7:0]  client;
  } rec_t;

  // what the whole row does this cycle
  typedef struct packed {
    logic insert;
    logic take;
  } cell_ctl_t;

  // true when a strictly beats b; on a full tie the record already held wins
  function automatic logic rec_beats(input rec_t a, input rec_t b);
    logic r;
    if (a.prio != b.prio) begin
      r = (a.prio > b.prio);
    end else if (a.arrival != b.arrival) begin
      r = (a.arrival < b.arrival);
    end else if (a.service != b.service) begin
      r = (a.service < b.service);
    end else begin
      r = (a.order < b.order);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* sv/lpq_cell.sv */
// one slot of the sorted record row
`default_nettype none

module lpq_cell
  import lpq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire cell_ctl_t ctl,
  input  wire rec_t      new_rec,
  input  wire rec_t      prev_rec,
  input  wire logic      prev_valid,
  input  wire logic      prev_claim,
  input  wire rec_t      next_rec,
  input  wire logic      next_valid,
  output rec_t           rec,
  output logic           valid,
  output logic           claim
);

  rec_t rec_next;
  logic valid_next;

  // new record belongs here or above when this slot is empty or loses to it
  assign claim = !valid || rec_beats(new_rec, rec);

  always_comb begin
    rec_next   = rec;
    valid_next = valid;
    if (ctl.insert) begin
      if (claim && !prev_claim) begin
        rec_next   = new_rec;
        valid_next = 1'b1;
      end else if (claim) begin
        rec_next   = prev_rec;
        valid_next = prev_valid;
      end
    end else if (ctl.take) begin
      rec_next   = next_rec;
      valid_next = next_valid;
    end
  end

  always_ff @(posedge clk) begin
    rec <= rec_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

endmodule

`default_nettype wire

/* sv/lexicographic_priority_queue_top.sv */
// top level of the lexicographic priority queue: command register, cell row, result register
//
// channel   direction  handshake               payload
// command   in         start & !busy           command, priority_req, arrival_time,
//                                              service_time, input_order, client_id
// result    out        done (one cycle strobe) found, best_client, status, entry_count
//
// in each transaction the accept edge latches the command, the next
// edge updates the cell row and latches the result, which shows for one cycle
// with done high while busy is already low again
// no new command is taken while busy; the row of QUEUE_DEPTH cells finishes an insert,
// take or peek in a single step, so the pace does not depend on the fill level
// rst is synchronous and empties the row at once, no clearing pass
// the receiver cannot stall: done is not held, but the outputs keep a result until the next one
`default_nettype none

module lexicographic_priority_queue_top
  import lpq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  command,
  input  wire logic [3:0]  priority_req,
  input  wire logic [15:0] arrival_time,
  input  wire logic [15:0] service_time,
  input  wire logic [15:0] input_order,
  input  wire logic [7:0]  client_id,
  output logic             done,
  output logic             found,
  output logic [7:0]       best_client,
  output logic [1:0]       status,
  output logic [4:0]       entry_count
);

  // latched command
  logic [1:0] cmd_q;
  rec_t       new_rec;

  // record count
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  // cell row wiring
  rec_t      cell_rec   [QUEUE_DEPTH];
  logic      cell_valid [QUEUE_DEPTH];
  logic      cell_claim [QUEUE_DEPTH];
  cell_ctl_t ctl;

  // result next values
  logic             found_next;
  logic [7:0]       client_next;
  logic [1:0]       status_next;

  wire logic accept = start && !busy;
  wire logic full   = (count == CNT_W'(QUEUE_DEPTH));

  // busy covers the one execute cycle after each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      busy <= accept;
      done <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q           <= command;
      new_rec.prio    <= priority_req;
      new_rec.arrival <= arrival_time;
      new_rec.service <= service_time;
      new_rec.order   <= input_order;
      new_rec.client  <= client_id;
    end
  end

  // decode the latched command into row control and the result
  always_comb begin
    ctl         = '0;
    found_next  = 1'b0;
    client_next = '0;
    status_next = ST_OK;
    count_next  = count;
    if (busy) begin
      unique case (cmd_q) inside
        CMD_INSERT: begin
          if (full) begin
            status_next = ST_FULL;
          end else begin
            ctl.insert = 1'b1;
            count_next = count + CNT_W'(1);
          end
        end
        CMD_TAKE, CMD_PEEK: begin
          if (!cell_valid[0]) begin
            status_next = ST_EMPTY;
          end else begin
            // head of the row is always the best record
            found_next  = 1'b1;
            client_next = cell_rec[0].client;
            if (cmd_q == CMD_TAKE) begin
              ctl.take   = 1'b1;
              count_next = count - CNT_W'(1);
            end
          end
        end
        default: begin
          // unused code: no operation, report the count as is
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // result register, loaded in the execute cycle
  always_ff @(posedge clk) begin
    if (busy) begin
      found       <= found_next;
      best_client <= client_next;
      status      <= status_next;
      entry_count <= ENTRY_W'(count_next);
    end
  end

  // sorted row, best record in cell 0; an insert shifts the losers down by one,
  // a take shifts everything up by one
  genvar g;
  generate
    for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      rec_t prev_rec;
      logic prev_valid;
      logic prev_claim;
      rec_t next_rec;
      logic next_valid;

      if (g == 0) begin : g_first
        assign prev_rec   = '0;
        assign prev_valid = 1'b0;
        assign prev_claim = 1'b0;
      end else begin : g_mid
        assign prev_rec   = cell_rec[g-1];
        assign prev_valid = cell_valid[g-1];
        assign prev_claim = cell_claim[g-1];
      end

      if (g == QUEUE_DEPTH - 1) begin : g_last
        assign next_rec   = '0;
        assign next_valid = 1'b0;
      end else begin : g_inner
        assign next_rec   = cell_rec[g+1];
        assign next_valid = cell_valid[g+1];
      end

      lpq_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctl        (ctl),
        .new_rec    (new_rec),
        .prev_rec   (prev_rec),
        .prev_valid (prev_valid),
        .prev_claim (prev_claim),
        .next_rec   (next_rec),
        .next_valid (next_valid),
        .rec        (cell_rec[g]),
        .valid      (cell_valid[g]),
        .claim      (cell_claim[g])
      );
    end
  endgenerate

endmodule

`default_nettype wire

/* sv/lpq_checker.sv */
// port level checks for the lexicographic priority queue, bound to the top level
`default_nettype none

module lpq_checker
  import lpq_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic [1:0]  command,
  input wire logic [3:0]  priority_req,
  input wire logic [15:0] arrival_time,
  input wire logic [15:0] service_time,
  input wire logic [15:0] input_order,
  input wire logic [7:0]  client_id,
  input wire logic        done,
  input wire logic        found,
  input wire logic [7:0]  best_client,
  input wire logic [1:0]  status,
  input wire logic [4:0]  entry_count
);

  // an accepted transaction keeps the block busy for the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  // every transaction yields a result right after the busy cycle, with busy low again
  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> done && !busy)
    else $error("result strobe missing after busy cycle");

  // no result without a transaction in flight
  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a transaction");

  // an empty report carries no record and a zero count
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_EMPTY |-> !found && best_client == 8'd0 && entry_count == 5'd0)
    else $error("empty status with inconsistent result");

  // the count never goes past the store size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> entry_count <= 5'(QUEUE_DEPTH))
    else $error("entry count beyond store size");

endmodule

bind lexicographic_priority_queue_top lpq_checker u_lpq_checker (.*);

`default_nettype wire

/* tb/sv/tb.sv */
// self-checking testbench for the lexicographic priority queue top level
module tb;
  import lpq_pkg::*;

  // the command port has a fourth code that the package leaves out: it does nothing
  localparam logic [1:0] CMD_NOP = 2'd3;
  // quiet cycles allowed before the run is called hung
  localparam int QUIET_LIMIT = 500;
  localparam int RANDOM_ITEMS = 600;

  // one result transaction as the block reports it
  typedef struct packed {
    logic       found;
    logic [7:0] client;
    logic [1:0] status;
    logic [4:0] count;
  } reply_t;

  // one row of the directed plan; typed rows carry a hand-written reply
  typedef struct {
    logic [1:0] cmd;
    rec_t       rec;
    bit         typed;
    reply_t     want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  command;
  logic [3:0]  priority_req;
  logic [15:0] arrival_time;
  logic [15:0] service_time;
  logic [15:0] input_order;
  logic [7:0]  client_id;
  logic        done;
  logic        found;
  logic [7:0]  best_client;
  logic [1:0]  status;
  logic [4:0]  entry_count;

  // predictor state: held records in insertion order, oldest first
  rec_t      held_recs[$];
  // replies predicted at accept time, oldest first
  reply_t    pending_replies[$];
  plan_row_t plan[$];
  reply_t    head;

  int errors;
  int quiet;
  int burst_left;
  int n_insert, n_refused, n_take, n_peek, n_empty, n_nop, n_checked, peak_fill;

  lexicographic_priority_queue_top dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .priority_req (priority_req),
    .arrival_time (arrival_time),
    .service_time (service_time),
    .input_order  (input_order),
    .client_id    (client_id),
    .done         (done),
    .found        (found),
    .best_client  (best_client),
    .status       (status),
    .entry_count  (entry_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic plan_row_t step_row(input logic [1:0] cmd, input rec_t rec,
                                         input bit typed = 1'b0, input reply_t want = '0);
    plan_row_t r;
    r.cmd   = cmd;
    r.rec   = rec;
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  // works out the reply of one accepted command and updates the held records
  task automatic predict_reply(input logic [1:0] cmd, input rec_t rec, output reply_t o);
    int best;
    o = '0;
    case (cmd)
      CMD_INSERT: begin
        n_insert++;
        if (held_recs.size() >= QUEUE_DEPTH) begin
          o.status = ST_FULL;
          n_refused++;
        end else begin
          held_recs.push_back(rec);
        end
      end
      CMD_TAKE, CMD_PEEK: begin
        if (cmd == CMD_TAKE) n_take++;
        else n_peek++;
        if (held_recs.size() == 0) begin
          o.status = ST_EMPTY;
          n_empty++;
        end else begin
          // rank key: priority up, then arrival, service and order down; a strict
          // win is needed to replace, so the oldest insertion keeps a full tie
          best = 0;
          for (int i = 1; i < held_recs.size(); i++) begin
            if ({held_recs[i].prio, ~held_recs[i].arrival, ~held_recs[i].service,
                 ~held_recs[i].order} >
                {held_recs[best].prio, ~held_recs[best].arrival,
                 ~held_recs[best].service, ~held_recs[best].order})
              best = i;
          end
          o.found  = 1'b1;
          o.client = held_recs[best].client;
          if (cmd == CMD_TAKE) held_recs.delete(best);
        end
      end
      default: n_nop++;
    endcase
    o.count = 5'(held_recs.size());
    if (held_recs.size() > peak_fill) peak_fill = held_recs.size();
  endtask

  // drives one command transaction; the sender idles only between bursts so that
  // start is never lowered and raised in the same step
  task automatic issue(input logic [1:0] cmd, input rec_t rec, input bit typed,
                       input reply_t want);
    reply_t predicted;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    start        <= 1'b1;
    command      <= cmd;
    priority_req <= rec.prio;
    arrival_time <= rec.arrival;
    service_time <= rec.service;
    input_order  <= rec.order;
    client_id    <= rec.client;
    // accepted at the first edge that sees start with busy low
    do @(posedge clk); while (busy);
    predict_reply(cmd, rec, predicted);
    pending_replies.push_back(typed ? want : predicted);
  endtask

  // result side: the receiver never stalls, every done cycle is one transaction
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_replies.size() == 0) begin
        $error("unexpected result: found=%0d best_client=%0h status=%0d entry_count=%0d",
               found, best_client, status, entry_count);
        errors++;
      end else begin
        head = pending_replies.pop_front();
        n_checked++;
        if (found !== head.found) begin
          $error("found: expected %0d, got %0d", head.found, found);
          errors++;
        end
        if (best_client !== head.client) begin
          $error("best_client: expected %0h, got %0h", head.client, best_client);
          errors++;
        end
        if (status !== head.status) begin
          $error("status: expected %0d, got %0d", head.status, status);
          errors++;
        end
        if (entry_count !== head.count) begin
          $error("entry_count: expected %0d, got %0d", head.count, entry_count);
          errors++;
        end
      end
    end
  end

  // watchdog: any accepted transaction on either side resets the quiet count
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("timeout: %0d cycles without a transaction", quiet);
      $display("tb: done, errors");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    rec_t       r;
    logic [1:0] c;
    int         n_real;
    int         seg_left;
    int         fill_pct;
    int         roll;

    rst          = 1'b1;
    start        = 1'b0;
    command      = CMD_INSERT;
    priority_req = '0;
    arrival_time = '0;
    service_time = '0;
    input_order  = '0;
    client_id    = '0;
    errors       = 0;
    quiet        = 0;
    burst_left   = 0;
    n_insert = 0; n_refused = 0; n_take = 0; n_peek = 0;
    n_empty = 0; n_nop = 0; n_checked = 0; peak_fill = 0;

    // directed plan: empty store, no-op, extremes of every field, each tie-break
    // level, peek on a single record, filling up to the refused insert, two takes
    plan.push_back(step_row(CMD_PEEK, '0, 1'b1, {1'b0, 8'h00, ST_EMPTY, 5'd0}));
    plan.push_back(step_row(CMD_TAKE, '1, 1'b1, {1'b0, 8'h00, ST_EMPTY, 5'd0}));
    plan.push_back(step_row(CMD_NOP, '1, 1'b1, {1'b0, 8'h00, ST_OK, 5'd0}));
    plan.push_back(step_row(CMD_INSERT, {4'h0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h00},
                            1'b1, {1'b0, 8'h00, ST_OK, 5'd1}));
    // a peek must leave a lone record in place
    plan.push_back(step_row(CMD_PEEK, '0, 1'b1, {1'b1, 8'h00, ST_OK, 5'd1}));
    plan.push_back(step_row(CMD_INSERT, {4'hF, 16'h0000, 16'h0000, 16'h0000, 8'hFF},
                            1'b1, {1'b0, 8'h00, ST_OK, 5'd2}));
    plan.push_back(step_row(CMD_PEEK, '1, 1'b1, {1'b1, 8'hFF, ST_OK, 5'd2}));
    // full tie, then ties broken by order, service and arrival
    plan.push_back(step_row(CMD_INSERT, {4'hF, 16'h0000, 16'h0000, 16'h0000, 8'h5A}));
    plan.push_back(step_row(CMD_INSERT, {4'hF, 16'h0000, 16'h0000, 16'h0001, 8'h11}));
    plan.push_back(step_row(CMD_INSERT, {4'hF, 16'h0000, 16'h0001, 16'h0000, 8'h22}));
    plan.push_back(step_row(CMD_INSERT, {4'hF, 16'h0001, 16'h0000, 16'h0000, 8'h33}));
    plan.push_back(step_row(CMD_PEEK, '0));
    plan.push_back(step_row(CMD_INSERT, {4'hE, 16'h0000, 16'h0000, 16'h0000, 8'h01}));
    plan.push_back(step_row(CMD_INSERT, {4'h1, 16'h8000, 16'h8000, 16'h8000, 8'h80}));
    plan.push_back(step_row(CMD_INSERT, {4'h8, 16'h1234, 16'h5678, 16'h9ABC, 8'h02}));
    plan.push_back(step_row(CMD_INSERT, {4'h8, 16'h1234, 16'h5678, 16'h9ABB, 8'h03}));
    plan.push_back(step_row(CMD_INSERT, {4'h8, 16'h1234, 16'h5677, 16'hFFFF, 8'h04}));
    plan.push_back(step_row(CMD_INSERT, {4'h8, 16'h1233, 16'hFFFF, 16'hFFFF, 8'h05}));
    plan.push_back(step_row(CMD_INSERT, {4'h7, 16'h0000, 16'h0000, 16'h0000, 8'h06}));
    plan.push_back(step_row(CMD_INSERT, {4'hF, 16'h0000, 16'h0000, 16'h0000, 8'h07}));
    plan.push_back(step_row(CMD_INSERT, {4'hA, 16'hAAAA, 16'h5555, 16'hAAAA, 8'hAA}));
    plan.push_back(step_row(CMD_INSERT, {4'h5, 16'h5555, 16'hAAAA, 16'h5555, 8'h55}));
    // store is full now, the record is dropped
    plan.push_back(step_row(CMD_INSERT, {4'hF, 16'h0000, 16'h0000, 16'h0000, 8'hEE},
                            1'b1, {1'b0, 8'h00, ST_FULL, 5'd16}));
    // takes with junk in the unused fields
    plan.push_back(step_row(CMD_TAKE, '1));
    plan.push_back(step_row(CMD_TAKE, {4'h0, 16'h0000, 16'hFFFF, 16'h0000, 8'hC3}));
    plan.push_back(step_row(CMD_NOP, '0, 1'b1, {1'b0, 8'h00, ST_OK, 5'd14}));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) issue(plan[i].cmd, plan[i].rec, plan[i].typed, plan[i].want);

    // random part: segments lean toward filling or draining so the store spends
    // time both full and empty; narrow field ranges make ties common
    n_real   = 0;
    seg_left = 0;
    fill_pct = 50;
    while (n_real < RANDOM_ITEMS) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(10, 60);
        roll     = $urandom_range(0, 2);
        fill_pct = (roll == 0) ? 15 : (roll == 1) ? 50 : 85;
      end
      seg_left--;
      r.prio    = 4'($urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(6, 7));
      r.arrival = 16'($urandom_range(0, 1) ? $urandom_range(0, 65535)
                                           : $urandom_range(0, 2));
      r.service = 16'($urandom_range(0, 1) ? $urandom_range(0, 65535)
                                           : $urandom_range(0, 2));
      r.order   = 16'($urandom_range(0, 1) ? $urandom_range(0, 65535)
                                           : $urandom_range(0, 2));
      r.client  = 8'($urandom_range(0, 255));
      roll      = $urandom_range(0, 99);
      if (roll < 4) begin
        c = CMD_NOP;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < fill_pct) c = CMD_INSERT;
        else if (roll < fill_pct + (100 - fill_pct) * 2 / 3) c = CMD_TAKE;
        else c = CMD_PEEK;
      end
      issue(c, r, 1'b0, '0);
      if (c != CMD_NOP) n_real++;
    end

    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    // keep the clock running to catch a stray result strobe
    repeat (6) @(posedge clk);

    $display("covered %0d results: %0d inserts (%0d refused as full), %0d takes, %0d peeks",
             n_checked, n_insert, n_refused, n_take, n_peek);
    $display("  %0d reads of an empty store, %0d no-ops, peak fill %0d of %0d",
             n_empty, n_nop, peak_fill, QUEUE_DEPTH);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

/* files.f */
sv/lpq_pkg.sv
sv/lpq_cell.sv
sv/lexicographic_priority_queue_top.sv
sv/lpq_checker.sv
tb/sv/tb.sv
